### hdl/mavg_pkg.sv
// Shared types and constants for the three-channel moving average block.
// No dependencies; every other file imports this package.
`default_nettype none

package mavg_pkg;

  // Width of one distance sample and of one average
  localparam int unsigned SAMPLE_W = 10;

  // Decoupling queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Number of channels handled in parallel
  localparam int unsigned NUM_CH = 3;

  // One input item: three readings in cm
  typedef struct packed {
    logic [SAMPLE_W-1:0] front_cm;
    logic [SAMPLE_W-1:0] right_cm;
    logic [SAMPLE_W-1:0] left_cm;
  } in_t;

  // One result item: three truncated averages
  typedef struct packed {
    logic [SAMPLE_W-1:0] front_avg;
    logic [SAMPLE_W-1:0] right_avg;
    logic [SAMPLE_W-1:0] left_avg;
  } out_t;

  // Back-end sequencer, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUT  = 4'b1000
  } back_state_e;

endpackage

`default_nettype wire

### hdl/mavg_fifo.sv
// Front end: two-entry queue that accepts input items and holds them
// until the back end is free. Depends on mavg_pkg.
`default_nettype none

module mavg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mavg_pkg::in_t  in_data_i,
  output logic           deq_valid_o,
  input  logic           deq_ready_i,
  output mavg_pkg::in_t  deq_data_o
);
  import mavg_pkg::*;

  in_t               entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  // Handshake
  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign deq_valid_o = (cnt_q != '0);
  assign deq_data_o  = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/mavg_back.sv
// Back end: sample rings, running sums, serial divider and output register.
// Depends on mavg_pkg.
`default_nettype none

module mavg_back #(
  parameter int unsigned WINDOW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  mavg_pkg::in_t   item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output mavg_pkg::out_t  res_o
);
  import mavg_pkg::*;

  localparam int unsigned SUM_W  = $clog2(((2 ** SAMPLE_W) - 1) * WINDOW + 1);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned DW     = SAMPLE_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SAMPLE_W);

  back_state_e         state_q, state_d;
  in_t                 item_q;
  in_t                 rd_q;
  in_t                 ring_mem [WINDOW];
  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q   [NUM_CH];
  logic [DW-1:0]       rem_q   [NUM_CH];
  logic [SAMPLE_W-1:0] quo_q   [NUM_CH];
  logic [DW-1:0]       dsh_q;
  logic [STEP_W-1:0]   step_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                pop;
  logic                full;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SAMPLE_W-1:0] new_s   [NUM_CH];
  logic [SAMPLE_W-1:0] old_s   [NUM_CH];
  logic [SUM_W-1:0]    sum_new [NUM_CH];
  logic [DW:0]         trial   [NUM_CH];
  logic                take    [NUM_CH];
  logic                load_out;

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign full         = (cnt_q == CNT_W'(WINDOW));
  assign cnt_inc      = full ? cnt_q : cnt_q + 1'b1;
  assign load_out     = (state_q == ST_PUT) && (!out_valid_q || res_ready_i);

  // Per-channel view of the new and the replaced sample.
  // Until the ring is full the slot was never written and reads as zero.
  always_comb begin
    new_s[0] = item_q.front_cm;
    new_s[1] = item_q.right_cm;
    new_s[2] = item_q.left_cm;
    old_s[0] = full ? rd_q.front_cm : '0;
    old_s[1] = full ? rd_q.right_cm : '0;
    old_s[2] = full ? rd_q.left_cm  : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sum_new[c] = sum_q[c] - SUM_W'(old_s[c]) + SUM_W'(new_s[c]);
      trial[c]   = {1'b0, rem_q[c]} - {1'b0, dsh_q};
      take[c]    = !trial[c][DW];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop) state_d = ST_UPD;
      ST_UPD:  state_d = ST_DIV;
      ST_DIV:  if (step_q == '0) state_d = ST_PUT;
      ST_PUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_UPD) begin
        cnt_q  <= cnt_inc;
        slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          sum_q[c] <= sum_new[c];
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: restoring divide, one quotient bit per cycle, MSB first
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= item_i;
    end
    case (state_q)
      ST_UPD: begin
        dsh_q  <= DW'(cnt_inc) << (SAMPLE_W - 1);
        step_q <= STEP_W'(SAMPLE_W - 1);
        for (int c = 0; c < NUM_CH; c++) begin
          rem_q[c] <= DW'(sum_new[c]);
          quo_q[c] <= '0;
        end
      end
      ST_DIV: begin
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          if (take[c]) begin
            rem_q[c] <= trial[c][DW-1:0];
          end
          quo_q[c] <= {quo_q[c][SAMPLE_W-2:0], take[c]};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q.front_avg <= quo_q[0];
      out_q.right_avg <= quo_q[1];
      out_q.left_avg  <= quo_q[2];
    end
  end

  // Sample ring: read old sample on pop, write new one during update
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= ring_mem[slot_q];
    end
    if (state_q == ST_UPD) begin
      ring_mem[slot_q] <= item_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

### hdl/three_channel_moving_average_top.sv
// Top level of the three-channel boxcar moving average.
// Depends on mavg_pkg, mavg_fifo and mavg_back.
`default_nettype none

// Each item carries three distance readings (front, right, left). For every
// item the block returns one result with the truncated average of the last
// WINDOW readings per channel, or of all readings so far while fewer than
// WINDOW have arrived. In the back end each item passes these steps in order:
// the replaced sample is fetched from the ring, the running sums are updated,
// the bit-serial divider runs (one quotient bit per cycle, all three channels
// in parallel) and the output register is loaded. The back end takes no new
// item until the previous one is in the output register. A two-entry input
// queue and the output register let both sides stall independently. No
// clearing pass is needed after reset.
module three_channel_moving_average_top #(
  parameter int unsigned WINDOW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mavg_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mavg_pkg::out_t  out_data_o
);
  import mavg_pkg::*;

  logic q_valid;
  logic q_ready;
  in_t  q_data;

  // Front: input queue
  mavg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .deq_valid_o (q_valid),
    .deq_ready_i (q_ready),
    .deq_data_o  (q_data)
  );

  // Back: rings, sums, divider
  mavg_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_data),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );

endmodule

`default_nettype wire

### hdl/mavg_checker.sv
// Port-level checker for the moving average top level, with its bind.
// Depends on mavg_pkg and three_channel_moving_average_top.
`default_nettype none

module mavg_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input mavg_pkg::in_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mavg_pkg::out_t  out_data_o
);
  import mavg_pkg::*;

  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // An offered input item holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed or dropped while stalled");

  // A shown result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // No result without an accepted item behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without pending item");

  // Queue plus back end plus output register bound the items in flight
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd4)
    else $error("too many items in flight");

  // Input stalls only when the queue really is full
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pending_q >= 4'd2)
    else $error("input stalled with room left");

endmodule

bind three_channel_moving_average_top mavg_checker u_mavg_checker (.*);

`default_nettype wire

### bench/tb_three_channel_moving_average_top.sv
// Self-checking bench for three_channel_moving_average_top: drives distance items,
// predicts the per-channel boxcar averages and compares every result item.
// Depends on mavg_pkg and the RTL of three_channel_moving_average_top.
module tb_three_channel_moving_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::*;

  localparam int unsigned WINDOW      = 10;
  localparam int unsigned RAND_ITEMS  = 750;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_SHOWN   = 100;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_e;

  // Predicts the truncated window averages and holds them until they come out
  class boxcar_predictor;
    bit [SAMPLE_W-1:0] ring [NUM_CH][WINDOW];
    int unsigned       sum [NUM_CH];
    int unsigned       slot;
    int unsigned       fill;
    out_t              pending_avgs[$];
    int unsigned       mismatch_cnt;
    int unsigned       result_idx;

    // Store the readings of one accepted item and queue the averages it yields
    function void take_reading(in_t d);
      bit [SAMPLE_W-1:0] smp [NUM_CH];
      int unsigned       quot [NUM_CH];
      out_t              avg;
      smp[0] = d.front_cm;
      smp[1] = d.right_cm;
      smp[2] = d.left_cm;
      if (fill < WINDOW) fill++;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        // oldest sample leaves the sum (zero while the ring is filling)
        sum[ch] = sum[ch] - ring[ch][slot] + smp[ch];
        ring[ch][slot] = smp[ch];
        quot[ch] = sum[ch] / fill;
      end
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      avg.front_avg = SAMPLE_W'(quot[0]);
      avg.right_avg = SAMPLE_W'(quot[1]);
      avg.left_avg  = SAMPLE_W'(quot[2]);
      pending_avgs.push_back(avg);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_cnt < MAX_SHOWN)
        $display("ERROR result %0d %s: got %0d, expected %0d", result_idx, what, got, want);
      mismatch_cnt++;
    endtask

    // Compare one result item against the oldest expectation
    task check_avg(out_t got);
      out_t want;
      if (pending_avgs.size() == 0) begin
        report_mismatch("with nothing pending", got, 0);
      end else begin
        want = pending_avgs.pop_front();
        if (got.front_avg !== want.front_avg)
          report_mismatch("front_avg", got.front_avg, want.front_avg);
        if (got.right_avg !== want.right_avg)
          report_mismatch("right_avg", got.right_avg, want.right_avg);
        if (got.left_avg !== want.left_avg)
          report_mismatch("left_avg", got.left_avg, want.left_avg);
      end
      result_idx++;
    endtask
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  boxcar_predictor boxcar = new;

  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_tick     = 0;
  rx_mode_e    rx_mode     = RX_OPEN;

  three_channel_moving_average_top #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("three_channel_moving_average_top test failed");
      $finish;
    end
  end

  // Receiver: check accepted results, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) boxcar.check_avg(out_data_o);
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 400);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready_i <= (rx_tick % 7 == 0);
      default:     out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Present one item and hold it until accepted
  task send_item(in_t d);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    boxcar.take_reading(d);
  endtask

  // At the end of a burst drop valid for a random gap, else count down the burst
  task pace_sender();
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Random reading, weighted toward the ends of the range
  function automatic logic [SAMPLE_W-1:0] pick_cm();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    in_t d;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty start, saturate and wrap the ring, then extremes per channel and walking-bit patterns
    send_item('{front_cm: '0, right_cm: '0, left_cm: '0});
    for (int i = 0; i < WINDOW + 1; i++)
      send_item('{front_cm: FULL_SCALE, right_cm: FULL_SCALE, left_cm: FULL_SCALE});
    send_item('{front_cm: FULL_SCALE, right_cm: '0, left_cm: 10'd512});
    send_item('{front_cm: '0, right_cm: FULL_SCALE, left_cm: 10'd1});
    send_item('{front_cm: 10'd512, right_cm: 10'd1, left_cm: FULL_SCALE});
    send_item('{front_cm: 10'd1, right_cm: 10'd2, left_cm: 10'd3});
    for (int k = 0; k < SAMPLE_W; k += 2) begin
      d.front_cm = 10'd1 << k;
      d.right_cm = 10'd1 << (SAMPLE_W - 1 - k);
      d.left_cm  = ~(10'd1 << k);
      send_item(d);
      pace_sender();
    end

    // Random items in bursts
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        // hold off until the block has drained completely
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (boxcar.pending_avgs.size() != 0);
      end
      d.front_cm = pick_cm();
      d.right_cm = pick_cm();
      d.left_cm  = pick_cm();
      send_item(d);
      if (n != RAND_ITEMS - 1) pace_sender();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for any stray result item
    while (boxcar.pending_avgs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (boxcar.mismatch_cnt == 0 && boxcar.pending_avgs.size() == 0) begin
      $display("three_channel_moving_average_top test passed");
    end else begin
      $display("three_channel_moving_average_top test failed");
    end
    $finish;
  end

endmodule
